// ----- rtl/core/dll_pkg.sv -----
package dll_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(POOL_DEPTH + 1);
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int FIELD_W    = 32;

    localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_DEPTH);

    localparam logic [2:0] KIND_APPEND = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_DELETE = 3'd2;
    localparam logic [2:0] KIND_LISTF  = 3'd3;
    localparam logic [2:0] KIND_LISTB  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_READ_CUR,
        CMD_STEP_FWD,
        CMD_STEP_BWD,
        CMD_EMIT_ITEM,
        CMD_EMIT_STATUS,
        CMD_ALLOC,
        CMD_LINK_TAIL,
        CMD_INS_NEW,
        CMD_INS_AFTER,
        CMD_INS_PREV,
        CMD_DEL_PREV,
        CMD_DEL_NEXT,
        CMD_DEL_FREE,
        CMD_START_SEARCH
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [1:0] status;
        logic       fwd;
    } ctl_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       cur_nil;
        logic       next_nil;
        logic       match;
        logic       walk_done;
        logic       pool_full;
        logic       out_busy;
    } sts_t;

endpackage

// ----- rtl/core/dll_ram.sv -----
module dll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/dll_datapath.sv -----
module dll_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dll_pkg::ctl_t                           ctl,
    output dll_pkg::sts_t                           sts,
    input  logic [2:0]                              in_kind,
    input  logic [dll_pkg::FIELD_W-1:0]             in_key,
    input  logic [dll_pkg::FIELD_W-1:0]             in_value,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [dll_pkg::FIELD_W-1:0]             out_item,
    output logic [1:0]                              out_status,
    output logic                                    out_last
);
    import dll_pkg::*;

    localparam int NODE_W = DATA_WIDTH + 2 * IDX_W;

    logic [2:0]            kind_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      tail_reg;
    logic [POOL_DEPTH-1:0] used_reg;
    logic [IDX_W-1:0]      cur_reg;
    logic [IDX_W-1:0]      new_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  ov_reg;
    logic [FIELD_W-1:0]    oitem_reg;
    logic [1:0]            ost_reg;
    logic                  olast_reg;
    // links of the node being unlinked, also the old successor on insert
    logic [IDX_W-1:0]      dpv_reg;
    logic [IDX_W-1:0]      dnx_reg;

    // node memory word: value, prev, next
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [NODE_W-1:0]     wdata;
    logic [ADDR_W-1:0]     raddr;
    logic [NODE_W-1:0]     rdata;
    logic [DATA_WIDTH-1:0] rd_val;
    logic [IDX_W-1:0]      rd_prev;
    logic [IDX_W-1:0]      rd_next;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      step_idx;
    logic                  fin;

    assign rd_val  = rdata[NODE_W-1 -: DATA_WIDTH];
    assign rd_prev = rdata[2*IDX_W-1 -: IDX_W];
    assign rd_next = rdata[IDX_W-1:0];

    dll_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        free_idx = NIL;
        for (int i = POOL_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign step_idx = ctl.fwd ? rd_next : rd_prev;
    assign fin = (step_idx >= NIL) || (cnt_reg + 1'b1 >= CNT_W'(POOL_DEPTH));

    always_comb
    begin
        raddr = cur_reg[ADDR_W-1:0];
        we    = 1'b0;
        waddr = cur_reg[ADDR_W-1:0];
        wdata = rdata;
        case (ctl.cmd)
            CMD_ALLOC:
            begin
                we    = 1'b1;
                waddr = free_idx[ADDR_W-1:0];
                wdata = {val_reg, tail_reg, NIL};
            end
            CMD_INS_NEW:
            begin
                we    = 1'b1;
                waddr = new_reg[ADDR_W-1:0];
                wdata = {val_reg, cur_reg, rd_next};
            end
            CMD_LINK_TAIL:
            begin
                we    = 1'b1;
                wdata = {rd_val, rd_prev, new_reg};
            end
            CMD_INS_AFTER:
            begin
                // node p now points at the node being claimed
                we    = 1'b1;
                wdata = {rd_val, rd_prev, free_idx};
            end
            CMD_INS_PREV:
            begin
                // cur holds old successor here; rdata is that node
                we    = 1'b1;
                wdata = {rd_val, new_reg, rd_next};
            end
            CMD_DEL_NEXT:
            begin
                // cur is the victim's prev; rdata is that node
                we    = !(cur_reg >= NIL);
                wdata = {rd_val, rd_prev, dnx_reg};
            end
            CMD_DEL_FREE:
            begin
                // cur is the victim's next; rdata is that node
                we    = !(cur_reg >= NIL);
                wdata = {rd_val, dpv_reg, rd_next};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NIL;
            tail_reg <= NIL;
            used_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (ctl.cmd) inside
                CMD_LOAD:
                begin
                    kind_reg <= in_kind;
                    key_reg  <= DATA_WIDTH'(signed'(in_key));
                    val_reg  <= DATA_WIDTH'(signed'(in_value));
                    cnt_reg  <= '0;
                end
                CMD_START_SEARCH:
                begin
                    cur_reg <= ctl.fwd ? head_reg : tail_reg;
                    cnt_reg <= '0;
                end
                CMD_STEP_FWD, CMD_STEP_BWD:
                begin
                    cur_reg <= step_idx;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                CMD_EMIT_ITEM:
                begin
                    ov_reg    <= 1'b1;
                    oitem_reg <= FIELD_W'(rd_val);
                    ost_reg   <= ST_OK;
                    olast_reg <= fin;
                    cur_reg   <= step_idx;
                    cnt_reg   <= cnt_reg + 1'b1;
                end
                CMD_EMIT_STATUS:
                begin
                    ov_reg    <= 1'b1;
                    oitem_reg <= '0;
                    ost_reg   <= ctl.status;
                    olast_reg <= 1'b1;
                end
                CMD_ALLOC:
                begin
                    used_reg[free_idx[ADDR_W-1:0]] <= 1'b1;
                    new_reg <= free_idx;
                    cur_reg <= tail_reg;
                    if (head_reg >= NIL || tail_reg >= NIL)
                    begin
                        head_reg <= free_idx;
                    end
                    tail_reg <= free_idx;
                end
                CMD_INS_AFTER:
                begin
                    // first step of insert: new node claimed, node p is rdata
                    used_reg[free_idx[ADDR_W-1:0]] <= 1'b1;
                    new_reg <= free_idx;
                    dnx_reg <= rd_next;
                end
                CMD_INS_NEW:
                begin
                    cur_reg <= dnx_reg;
                    if (dnx_reg >= NIL)
                    begin
                        tail_reg <= new_reg;
                    end
                end
                CMD_DEL_PREV:
                begin
                    dpv_reg <= rd_prev;
                    dnx_reg <= rd_next;
                    used_reg[cur_reg[ADDR_W-1:0]] <= 1'b0;
                    if (rd_prev >= NIL)
                    begin
                        head_reg <= rd_next;
                    end
                    cur_reg <= rd_prev;
                end
                CMD_DEL_NEXT:
                begin
                    cur_reg <= dnx_reg;
                end
                CMD_DEL_FREE:
                begin
                    if (dnx_reg >= NIL)
                    begin
                        tail_reg <= dpv_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign sts.kind      = kind_reg;
    assign sts.cur_nil   = cur_reg >= NIL;
    assign sts.next_nil  = fin;
    assign sts.match     = rd_val == key_reg;
    assign sts.walk_done = cnt_reg >= CNT_W'(POOL_DEPTH);
    assign sts.pool_full = free_idx >= NIL;
    assign sts.out_busy  = ov_reg;

    assign out_valid  = ov_reg;
    assign out_item   = oitem_reg;
    assign out_status = ost_reg;
    assign out_last   = olast_reg;

endmodule

// ----- rtl/core/dll_ctrl.sv -----
module dll_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dll_pkg::sts_t sts,
    output dll_pkg::ctl_t ctl
);
    import dll_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_SCMP   = 4'd3;
    localparam logic [3:0] S_LREAD  = 4'd4;
    localparam logic [3:0] S_LEMIT  = 4'd5;
    localparam logic [3:0] S_APPRD  = 4'd6;
    localparam logic [3:0] S_APPLNK = 4'd7;
    localparam logic [3:0] S_INSNEW = 4'd8;
    localparam logic [3:0] S_INSRD  = 4'd9;
    localparam logic [3:0] S_INSPRV = 4'd10;
    localparam logic [3:0] S_DELRD  = 4'd11;
    localparam logic [3:0] S_DELNX  = 4'd12;
    localparam logic [3:0] S_DELRD2 = 4'd13;
    localparam logic [3:0] S_DELPV  = 4'd14;
    localparam logic [3:0] S_RESP   = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] st_reg;
    logic [1:0] st_next;
    logic       rd_wait_reg;
    logic       rd_wait_next;

    assign in_ready = (state_reg == S_IDLE) && !sts.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            st_reg      <= ST_OK;
            rd_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            st_reg      <= st_next;
            rd_wait_reg <= rd_wait_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        st_next      = st_reg;
        rd_wait_next = 1'b0;
        ctl.cmd      = CMD_NONE;
        ctl.status   = st_reg;
        ctl.fwd      = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ctl.cmd    = CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                st_next = ST_OK;
                if (sts.kind == KIND_APPEND)
                begin
                    if (sts.pool_full)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        ctl.cmd    = CMD_ALLOC;
                        state_next = S_APPRD;
                    end
                end
                else if (sts.kind == KIND_INSERT || sts.kind == KIND_DELETE
                         || sts.kind == KIND_LISTF)
                begin
                    ctl.cmd    = CMD_START_SEARCH;
                    state_next = (sts.kind == KIND_LISTF) ? S_LREAD : S_SRCH;
                end
                else if (sts.kind == KIND_LISTB)
                begin
                    ctl.cmd    = CMD_START_SEARCH;
                    ctl.fwd    = 1'b0;
                    state_next = S_LREAD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            // search: read cur, then compare
            S_SRCH:
            begin
                if (sts.cur_nil || sts.walk_done)
                begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (sts.match)
                begin
                    if (sts.kind == KIND_INSERT)
                    begin
                        if (sts.pool_full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            ctl.cmd    = CMD_INS_AFTER;
                            state_next = S_INSNEW;
                        end
                    end
                    else
                    begin
                        ctl.cmd    = CMD_DEL_PREV;
                        state_next = S_DELRD;
                    end
                end
                else
                begin
                    ctl.cmd    = CMD_STEP_FWD;
                    state_next = S_SRCH;
                end
            end
            S_LREAD:
            begin
                ctl.fwd = (sts.kind == KIND_LISTF);
                if (rd_wait_reg)
                begin
                    state_next = S_LEMIT;
                end
                else if (sts.cur_nil)
                begin
                    st_next    = ST_EMPTY;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_wait_next = 1'b1;
                end
            end
            S_LEMIT:
            begin
                ctl.fwd = (sts.kind == KIND_LISTF);
                if (!sts.out_busy)
                begin
                    ctl.cmd    = CMD_EMIT_ITEM;
                    state_next = sts.next_nil ? S_IDLE : S_LREAD;
                    rd_wait_next = 1'b1;
                end
            end
            // append: ram read of old tail, then link it
            S_APPRD:
            begin
                state_next = sts.cur_nil ? S_RESP : S_APPLNK;
            end
            S_APPLNK:
            begin
                ctl.cmd    = CMD_LINK_TAIL;
                state_next = S_RESP;
            end
            S_INSNEW:
            begin
                ctl.cmd    = CMD_INS_NEW;
                state_next = S_INSRD;
            end
            S_INSRD:
            begin
                // read of the old successor
                state_next = S_INSPRV;
            end
            S_INSPRV:
            begin
                if (sts.cur_nil)
                begin
                    state_next = S_RESP;
                end
                else if (rd_wait_reg)
                begin
                    ctl.cmd    = CMD_INS_PREV;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_wait_next = 1'b1;
                end
            end
            S_DELRD:
            begin
                // cur now victim's prev; its read in flight
                state_next = S_DELNX;
            end
            S_DELNX:
            begin
                ctl.cmd    = CMD_DEL_NEXT;
                state_next = S_DELRD2;
            end
            S_DELRD2:
            begin
                state_next = S_DELPV;
            end
            S_DELPV:
            begin
                ctl.cmd    = CMD_DEL_FREE;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!sts.out_busy)
                begin
                    ctl.cmd    = CMD_EMIT_STATUS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/doubly_linked_list_engine.sv -----
// Doubly linked list over a 16-node pool held in one node memory (value,
// prev, next) with a registered read port. One input word is one operation:
// append, insert after key, delete key, list forward, list backward. Each
// operation gives one output word with last set, except a listing, which
// gives one word per node. Items are taken one at a time; a search and a
// listing walk the nodes one by one, and relinking follows, all through
// the single read port of the node memory.
module doubly_linked_list_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // kind[2:0], key[34:3], value[66:35], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // item_value[31:0], status[33:32], zero pad
    output logic        m_tlast
);
    import dll_pkg::*;

    ctl_t ctl;
    sts_t sts;
    logic [FIELD_W-1:0] out_item;
    logic [1:0]         out_status;

    dll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    dll_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_kind    (s_tdata[2:0]),
        .in_key     (s_tdata[34:3]),
        .in_value   (s_tdata[66:35]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (out_item),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {6'd0, out_status, out_item};

endmodule

// ----- tb/tb_doubly_linked_list_engine.sv -----
module tb_doubly_linked_list_engine;
    import dll_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        logic [31:0] item_value;
        logic [1:0]  status;
        logic        last;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // shadow of the node pool
    logic [31:0] pool_val [DEPTH];
    int          pool_prev [DEPTH];
    int          pool_next [DEPTH];
    bit          pool_used [DEPTH];
    int          head_ptr;
    int          tail_ptr;

    word_t       pending_words[$];
    int          error_count;
    bit          sink_stall_en;
    bit          source_idle_en;
    int          stall_left;

    doubly_linked_list_engine uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int lowest_free();
        for (int i = 0; i < DEPTH; i++)
            if (!pool_used[i])
                return i;
        return DEPTH;
    endfunction

    function automatic int search_key(logic [31:0] k);
        int p;
        p = head_ptr;
        for (int n = 0; n < DEPTH && p < DEPTH; n++)
        begin
            if (pool_val[p] == k)
                return p;
            p = pool_next[p];
        end
        return DEPTH;
    endfunction

    function automatic void push_word(logic [31:0] v, logic [1:0] st, logic lst);
        word_t w;
        w.item_value = v;
        w.status = st;
        w.last = lst;
        pending_words.push_back(w);
    endfunction

    function automatic void predict_op(logic [2:0] kind, logic [31:0] k, logic [31:0] v);
        int p;
        int n;
        int a;
        int cnt;
        logic [1:0] st;
        st = ST_OK;
        case (kind)
            KIND_APPEND:
            begin
                n = lowest_free();
                if (n == DEPTH)
                    st = ST_FULL;
                else
                begin
                    pool_used[n] = 1;
                    pool_val[n] = v;
                    pool_next[n] = DEPTH;
                    if (head_ptr == DEPTH || tail_ptr == DEPTH)
                    begin
                        pool_prev[n] = DEPTH;
                        head_ptr = n;
                    end
                    else
                    begin
                        pool_prev[n] = tail_ptr;
                        pool_next[tail_ptr] = n;
                    end
                    tail_ptr = n;
                end
            end
            KIND_INSERT:
            begin
                p = search_key(k);
                n = lowest_free();
                if (p == DEPTH)
                    st = ST_NOTFOUND;
                else if (n == DEPTH)
                    st = ST_FULL;
                else
                begin
                    a = pool_next[p];
                    pool_used[n] = 1;
                    pool_val[n] = v;
                    pool_prev[n] = p;
                    pool_next[n] = a;
                    if (a < DEPTH)
                        pool_prev[a] = n;
                    else
                        tail_ptr = n;
                    pool_next[p] = n;
                end
            end
            KIND_DELETE:
            begin
                p = search_key(k);
                if (p == DEPTH)
                    st = ST_NOTFOUND;
                else
                begin
                    if (pool_prev[p] < DEPTH)
                        pool_next[pool_prev[p]] = pool_next[p];
                    else
                        head_ptr = pool_next[p];
                    if (pool_next[p] < DEPTH)
                        pool_prev[pool_next[p]] = pool_prev[p];
                    else
                        tail_ptr = pool_prev[p];
                    pool_used[p] = 0;
                end
            end
            KIND_LISTF, KIND_LISTB:
            begin
                p = (kind == KIND_LISTF) ? head_ptr : tail_ptr;
                if (p == DEPTH)
                    push_word('0, ST_EMPTY, 1'b1);
                cnt = 0;
                while (p < DEPTH && cnt < DEPTH)
                begin
                    n = (kind == KIND_LISTF) ? pool_next[p] : pool_prev[p];
                    push_word(pool_val[p], ST_OK, (n == DEPTH) || (cnt + 1 >= DEPTH));
                    cnt++;
                    p = n;
                end
                return;
            end
            default: ;
        endcase
        push_word('0, st, 1'b1);
    endfunction

    task automatic send_op(logic [2:0] kind, logic [31:0] k, logic [31:0] v);
        int gap;
        @(negedge clk);
        if (source_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        predict_op(kind, k, v);
        s_tdata <= {5'd0, v, k, kind};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    function automatic logic [31:0] present_value();
        int live[$];
        for (int i = 0; i < DEPTH; i++)
            if (pool_used[i])
                live.push_back(i);
        if (live.size() == 0 || $urandom_range(0, 4) == 0)
            return $urandom;
        return pool_val[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    task automatic test_empty_list();
        send_op(KIND_LISTF, '0, '0);
        send_op(KIND_LISTB, '0, '0);
        send_op(KIND_DELETE, 32'h1234, '0);
        send_op(KIND_INSERT, 32'h1234, 32'h5);
        send_op(3'd5, '1, '1);
        send_op(3'd7, '0, '0);
    endtask

    task automatic test_fill_and_full();
        for (int i = 0; i < DEPTH; i++)
            send_op(KIND_APPEND, '0, (i == 0) ? 32'h8000_0000 :
                                     (i == 1) ? 32'h7fff_ffff : 32'(i * 3));
        send_op(KIND_APPEND, '0, 32'hffff_ffff);
        send_op(KIND_INSERT, 32'h7fff_ffff, 32'h1);
        send_op(KIND_INSERT, 32'hdead_beef, 32'h1);
        send_op(KIND_LISTF, '0, '0);
        send_op(KIND_LISTB, '0, '0);
        drain();
    endtask

    task automatic test_relink();
        send_op(KIND_DELETE, 32'h8000_0000, '0);
        send_op(KIND_DELETE, 32'd45, '0);
        send_op(KIND_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        send_op(KIND_INSERT, 32'd42, 32'h0);
        send_op(KIND_LISTF, '0, '0);
        send_op(KIND_LISTB, '0, '0);
        for (int i = 0; i < DEPTH; i++)
            send_op(KIND_DELETE, present_value(), '0);
        drain();
    endtask

    task automatic test_random(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_op(KIND_APPEND, $urandom, present_value());
            else if (r < 50)
                send_op(KIND_INSERT, present_value(), $urandom);
            else if (r < 72)
                send_op(KIND_DELETE, present_value(), $urandom);
            else if (r < 84)
                send_op(KIND_LISTF, $urandom, $urandom);
            else if (r < 96)
                send_op(KIND_LISTB, $urandom, $urandom);
            else
                send_op(3'($urandom_range(5, 7)), $urandom, $urandom);
            if (i == count / 2)
                drain();
        end
    endtask

    // sink side stall, in bursts started at random
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (sink_stall_en && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word value=%h status=%0d last=%0b",
                         $time, m_tdata[31:0], m_tdata[33:32], m_tlast);
                error_count++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (m_tdata[31:0] !== w.item_value || m_tdata[33:32] !== w.status ||
                    m_tlast !== w.last)
                begin
                    $display("%0t: mismatch expected value=%h status=%0d last=%0b",
                             $time, w.item_value, w.status, w.last);
                    $display("%0t:          actual   value=%h status=%0d last=%0b",
                             $time, m_tdata[31:0], m_tdata[33:32], m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        error_count = 0;
        sink_stall_en = 1'b1;
        source_idle_en = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            pool_used[i] = 0;
        head_ptr = DEPTH;
        tail_ptr = DEPTH;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_list();
        test_fill_and_full();
        test_relink();
        test_random(290);
        sink_stall_en = 1'b0;
        source_idle_en = 1'b0;
        test_random(80);
        drain();
        if (error_count == 0 && pending_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
